@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the compatible set search block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define A_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define A_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/mwcs_pkg.sv @@
// Types and constants of the compatible set search block.
// Depends on nothing; imported by every module of the block.
package mwcs_pkg;

    localparam int MASK_W   = 64;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 40;
    localparam int TOTAL_W  = 37;
    localparam int ROW_W    = 6;
    localparam int CNT_W    = 7;

    // One stack frame of the depth-first search
    typedef struct packed {
        logic [MASK_W-1:0]        cand;
        logic [MASK_W-1:0]        chosen;
        logic signed [SUM_W-1:0]  sum;
        logic                     phase;
    } t_frame;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_IDX,
        S_NODE,
        S_EVAL,
        S_SWEEP,
        S_CMP,
        S_ENTER,
        S_DONE
    } t_state;

    // Position of the lowest set bit; 63 when the mask is empty
    function automatic logic [ROW_W-1:0] f_lowest(input logic [MASK_W-1:0] m);
        logic [ROW_W-1:0] idx;
        idx = ROW_W'(MASK_W - 1);
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) idx = ROW_W'(i);
        end
        return idx;
    endfunction

endpackage

@@ rtl/mwcs_store.sv @@
// Problem store: compatibility rows and item weights, one synchronous memory each.
// Depends on mwcs_pkg.
module mwcs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [AW-1:0]                        i_waddr,
    input  logic [mwcs_pkg::MASK_W-1:0]          i_wrow,
    input  logic signed [mwcs_pkg::WEIGHT_W-1:0] i_wweight,
    input  logic [AW-1:0]                        i_row_raddr,
    input  logic [AW-1:0]                        i_weight_raddr,
    output logic [mwcs_pkg::MASK_W-1:0]          o_row,
    output logic signed [mwcs_pkg::WEIGHT_W-1:0] o_weight
);
    import mwcs_pkg::*;

    logic [MASK_W-1:0]          r_row_mem    [DEPTH];
    logic signed [WEIGHT_W-1:0] r_weight_mem [DEPTH];

    // Write loaded rows and weights; reads are registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_row_mem[i_waddr]    <= i_wrow;
            r_weight_mem[i_waddr] <= i_wweight;
        end
        o_row    <= r_row_mem[i_row_raddr];
        o_weight <= r_weight_mem[i_weight_raddr];
    end

endmodule

@@ rtl/mwcs_stack.sv @@
// Search stack: one frame per entry in a synchronous memory.
// Depends on mwcs_pkg.
module mwcs_stack #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  mwcs_pkg::t_frame i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output mwcs_pkg::t_frame o_rdata
);
    import mwcs_pkg::*;

    t_frame r_mem [DEPTH];

    // Write a frame, read the top frame and hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/max_weight_compatible_set_search_top.sv @@
// Top level of the maximum weight compatible set search: control sequencer.
// Depends on mwcs_pkg, assert_macros.svh, mwcs_store and mwcs_stack.
//
// Usage: each input word loads one compatibility row and one signed weight
// for item row_index (rows at or above MAX_ITEMS are not stored). A word
// with last_row set also starts a depth-first branch-and-bound search over
// the first items_in_use items. Rows load one per cycle while the block is
// idle. The search time then depends on the data. Each frame is stepped
// twice, once per branch. A step reads the frame and its row, then pushes a
// child or marks a leaf. A bound check first sums the weights of the
// remaining candidates and compares. This sequencing is set by the single
// read port of the weight memory and the stack memory. After the walk ends,
// the result word (best total and best set) is held in an output register
// until taken; while it waits further rows load normally, and a new search
// runs but holds its result until the previous word is taken.
// The configuration channel writes items_in_use and is always ready. Reset
// sets items_in_use to 64 and clears the control state; the stored rows are
// undefined until written.
module max_weight_compatible_set_search_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwcs_pkg::CNT_W-1:0]           i_cfg_items_in_use,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mwcs_pkg::ROW_W-1:0]           i_row_index,
    input  logic [mwcs_pkg::MASK_W-1:0]          i_compat_row,
    input  logic signed [mwcs_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                 i_last_row,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mwcs_pkg::TOTAL_W-1:0]         o_best_total,
    output logic [mwcs_pkg::MASK_W-1:0]          o_best_set
);
    import mwcs_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DW = $clog2(MAX_ITEMS + 1);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_items, n_items;
    logic [DW-1:0]           r_depth, n_depth;
    logic signed [SUM_W-1:0] r_best_sum, n_best_sum;
    logic [MASK_W-1:0]       r_best_mask, n_best_mask;
    logic                    r_leaf, n_leaf;
    logic [AW-1:0]           r_idx, n_idx;
    logic signed [SUM_W-1:0] r_inc_sum, n_inc_sum;
    logic [MASK_W-1:0]       r_child, n_child;
    logic [MASK_W-1:0]       r_child_chosen, n_child_chosen;
    logic signed [SUM_W-1:0] r_child_sum, n_child_sum;
    logic [MASK_W-1:0]       r_rem, n_rem;
    logic                    r_pend, n_pend;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]      r_out_total, n_out_total;
    logic [MASK_W-1:0]       r_out_set, n_out_set;

    logic                    w_load_we;
    logic [MASK_W-1:0]       w_row;
    logic signed [WEIGHT_W-1:0] w_weight;
    logic signed [SUM_W-1:0] w_weight_x;
    logic [MASK_W-1:0]       w_enc_in;
    logic [ROW_W-1:0]        w_enc_idx;
    logic [AW-1:0]           w_weight_raddr;
    logic                    w_stk_we, w_stk_re;
    logic [AW-1:0]           w_stk_waddr;
    t_frame                  w_stk_wdata, w_frame;
    logic [DW-1:0]           w_top;
    logic [CNT_W-1:0]        w_n;
    logic [MASK_W-1:0]       w_all;
    logic [MASK_W-1:0]       w_bit;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_best_total = r_out_total;
    assign o_best_set   = r_out_set;

    assign w_load_we = i_in_valid && o_in_ready && (32'(i_row_index) < MAX_ITEMS);
    assign w_top     = r_depth - DW'(1);
    assign w_weight_x = {{(SUM_W - WEIGHT_W){w_weight[WEIGHT_W-1]}}, w_weight};
    assign w_bit     = MASK_W'(1) << r_idx;

    // Share one lowest-bit encoder between node and bound sweep
    assign w_enc_in       = (r_state == S_SWEEP) ? r_rem : w_frame.cand;
    assign w_enc_idx      = f_lowest(w_enc_in);
    assign w_weight_raddr = w_enc_idx[AW-1:0];

    // Initial candidate mask from the saturated item count
    always_comb begin
        w_n = (32'(r_items) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS) : r_items;
        for (int i = 0; i < MASK_W; i++) begin
            w_all[i] = (CNT_W'(i) < w_n);
        end
    end

    mwcs_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
        .i_clk          (i_clk),
        .i_we           (w_load_we),
        .i_waddr        (i_row_index[AW-1:0]),
        .i_wrow         (i_compat_row),
        .i_wweight      (i_weight),
        .i_row_raddr    (w_weight_raddr),
        .i_weight_raddr (w_weight_raddr),
        .o_row          (w_row),
        .o_weight       (w_weight)
    );

    mwcs_stack #(.DEPTH(MAX_ITEMS), .AW(AW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_top[AW-1:0]),
        .o_rdata (w_frame)
    );

    // Sequence the search: pop, evaluate, check bound, push
    always_comb begin
        n_state        = r_state;
        n_items        = r_items;
        n_depth        = r_depth;
        n_best_sum     = r_best_sum;
        n_best_mask    = r_best_mask;
        n_leaf         = r_leaf;
        n_idx          = r_idx;
        n_inc_sum      = r_inc_sum;
        n_child        = r_child;
        n_child_chosen = r_child_chosen;
        n_child_sum    = r_child_sum;
        n_rem          = r_rem;
        n_pend         = r_pend;
        n_acc          = r_acc;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_total    = r_out_total;
        n_out_set      = r_out_set;
        w_stk_we       = 1'b0;
        w_stk_re       = 1'b0;
        w_stk_waddr    = r_depth[AW-1:0];
        w_stk_wdata    = '{cand: r_child, chosen: r_child_chosen, sum: r_child_sum,
                           phase: 1'b0};

        if (i_cfg_valid) begin
            n_items = i_cfg_items_in_use;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_last_row) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_best_sum  = '0;
                n_best_mask = '0;
                n_depth     = '0;
                n_leaf      = (w_all == '0);
                n_state     = S_DONE;
                if (w_all != '0) begin
                    w_stk_we    = 1'b1;
                    w_stk_waddr = '0;
                    w_stk_wdata = '{cand: w_all, chosen: '0, sum: '0, phase: 1'b0};
                    n_depth     = DW'(1);
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                if (r_depth == '0) begin
                    n_state = S_DONE;
                end else begin
                    w_stk_re = 1'b1;
                    n_state  = S_IDX;
                end
            end
            S_IDX: begin
                n_idx   = w_enc_idx[AW-1:0];
                n_state = S_NODE;
            end
            S_NODE: begin
                n_inc_sum = w_frame.sum + w_weight_x;
                if (!w_frame.phase) begin
                    n_child        = w_row & w_frame.cand & ~w_bit;
                    n_child_chosen = w_frame.chosen | w_bit;
                    n_child_sum    = w_frame.sum + w_weight_x;
                    // Mark the top frame for its exclude branch
                    w_stk_we    = 1'b1;
                    w_stk_waddr = w_top[AW-1:0];
                    w_stk_wdata = '{cand: w_frame.cand, chosen: w_frame.chosen,
                                    sum: w_frame.sum, phase: 1'b1};
                end else begin
                    n_child        = w_frame.cand & ~w_bit;
                    n_child_chosen = w_frame.chosen;
                    n_child_sum    = w_frame.sum;
                    n_depth        = w_top;
                end
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!w_frame.phase && (r_inc_sum > r_best_sum)) begin
                    n_best_sum  = r_inc_sum;
                    n_best_mask = r_child_chosen;
                end
                n_rem  = r_child;
                n_pend = 1'b0;
                n_acc  = '0;
                if (w_frame.phase || r_leaf) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_ENTER;
                end
            end
            S_SWEEP: begin
                // Issue one weight read per set bit, add the previous one
                if (r_pend) begin
                    n_acc = r_acc + w_weight_x;
                end
                n_pend = (r_rem != '0);
                if (r_rem != '0) begin
                    n_rem = r_rem & ~(MASK_W'(1) << w_enc_idx);
                end
                if ((r_rem == '0) && !r_pend) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_inc_sum + r_acc > r_best_sum) begin
                    n_state = S_ENTER;
                end else begin
                    n_state = S_POP;
                end
            end
            S_ENTER: begin
                if (r_child == '0) begin
                    n_leaf = 1'b1;
                end else begin
                    w_stk_we = 1'b1;
                    n_depth  = r_depth + DW'(1);
                end
                n_state = S_POP;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_best_sum[TOTAL_W-1:0];
                    n_out_set   = r_best_mask;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_items     <= CNT_W'(64);
            r_depth     <= '0;
            r_best_sum  <= '0;
            r_best_mask <= '0;
            r_leaf      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_items     <= n_items;
            r_depth     <= n_depth;
            r_best_sum  <= n_best_sum;
            r_best_mask <= n_best_mask;
            r_leaf      <= n_leaf;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_inc_sum      <= n_inc_sum;
        r_child        <= n_child;
        r_child_chosen <= n_child_chosen;
        r_child_sum    <= n_child_sum;
        r_rem          <= n_rem;
        r_acc          <= n_acc;
        r_out_total    <= n_out_total;
        r_out_set      <= n_out_set;
    end

    `A_ALWAYS(a_depth_bound, i_clk, i_rst_n, 32'(r_depth) <= MAX_ITEMS, "stack overflow")
    `A_ALWAYS(a_best_nonneg, i_clk, i_rst_n, !r_best_sum[SUM_W-1], "negative best sum")
    `A_IMPLY(a_push_room, i_clk, i_rst_n, (r_state == S_ENTER) && (r_child != '0), 32'(r_depth) < MAX_ITEMS, "push on full stack")

endmodule
